>>> hdl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Types and constants shared by the tar stream deframer and its output interface.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned SIZE_W = 33;
  localparam int unsigned NUM_W  = 21;

  // block phase codes
  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_CONTENT = 2'd1;
  localparam logic [1:0] PH_END     = 2'd2;

  // ustar header layout
  localparam int unsigned MODE_OFF  = 100;
  localparam int unsigned MODE_LEN  = 8;
  localparam int unsigned SIZE_OFF  = 124;
  localparam int unsigned SIZE_LEN  = 12;
  localparam int unsigned TYPE_OFF  = 156;
  localparam int unsigned MAJOR_OFF = 329;
  localparam int unsigned MINOR_OFF = 337;
  localparam int unsigned DEV_LEN   = 8;

  // bit positions in the field stop mask
  localparam int unsigned FLD_SIZE  = 0;
  localparam int unsigned FLD_MODE  = 1;
  localparam int unsigned FLD_MAJOR = 2;
  localparam int unsigned FLD_MINOR = 3;
  localparam int unsigned NUM_FLDS  = 4;

  localparam logic [7:0] TYPE_LINK_LO = 8'h31;  // '1'
  localparam logic [7:0] TYPE_LINK_HI = 8'h36;  // '6'

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_PAD      = 3'd2,
    KIND_END      = 3'd3,
    KIND_FEED_END = 3'd4,
    KIND_DROPPED  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_EARLY_END = 2'd1,
    ERR_TRAILING  = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0]        byte_out;
    kind_e             byte_kind;
    logic              header_done;
    logic              archive_end;
    logic              has_content;
    logic [7:0]        entry_type;
    logic [SIZE_W-1:0] file_size;
    logic [NUM_W-1:0]  file_mode;
    logic [NUM_W-1:0]  dev_major;
    logic [NUM_W-1:0]  dev_minor;
    err_e              error_code;
  } result_t;

endpackage

>>> hdl/tsd_in_if.sv
// ----------------------------------------------------------------------------
// tsd_in_if
// Byte channel into the deframer: one archive byte or an end of feed per beat.
// ----------------------------------------------------------------------------
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_feed;

  modport source (output valid, output data_byte, output end_of_feed, input ready);
  modport sink   (input valid, input data_byte, input end_of_feed, output ready);
endinterface

>>> hdl/tsd_out_if.sv
// ----------------------------------------------------------------------------
// tsd_out_if
// Result channel of the deframer: one classified byte per beat.
// ----------------------------------------------------------------------------
interface tsd_out_if
  import tsd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [7:0]        byte_out;
  logic [2:0]        byte_kind;
  logic              header_done;
  logic              archive_end;
  logic              has_content;
  logic [7:0]        entry_type;
  logic [SIZE_W-1:0] file_size;
  logic [NUM_W-1:0]  file_mode;
  logic [NUM_W-1:0]  dev_major;
  logic [NUM_W-1:0]  dev_minor;
  logic [1:0]        error_code;

  modport source (
    output valid, output byte_out, output byte_kind, output header_done,
    output archive_end, output has_content, output entry_type, output file_size,
    output file_mode, output dev_major, output dev_minor, output error_code,
    input ready
  );
  modport sink (
    input valid, input byte_out, input byte_kind, input header_done,
    input archive_end, input has_content, input entry_type, input file_size,
    input file_mode, input dev_major, input dev_minor, input error_code,
    output ready
  );
endinterface

>>> hdl/tar_stream_deframer.sv
// ----------------------------------------------------------------------------
// tar_stream_deframer
// Splits a ustar byte stream into 512-byte blocks, parses header fields and
// tags every byte as header, file data, padding, end marker or dropped.
// ----------------------------------------------------------------------------
// One byte (or end-of-feed beat) is accepted per cycle unless the output
// stalls, and its result is offered on the output from the result register:
// the beat lands in an input register, the block state and the result
// register are updated from it in one pass of counter, octal shift-add and
// compare logic. The result register decouples the sides, so a stalled
// output only holds off input once both registers are full. Header fields
// appear on the result of the last byte of a header block; the error code is
// sticky until reset and every byte after an error is reported as dropped.
module tar_stream_deframer
  import tsd_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsd_in_if.sink    in_i,
  tsd_out_if.source out_o
);

  localparam int unsigned OFF_W = $clog2(BLOCK_BYTES);
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(BLOCK_BYTES - 1);

  // input register
  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_eof_q;
  logic       s0_fire;

  // block state
  logic [1:0]          phase_q, phase_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic                az_q, az_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [NUM_W-1:0]    mode_q, mode_d;
  logic [NUM_W-1:0]    major_q, major_d;
  logic [NUM_W-1:0]    minor_q, minor_d;
  logic [NUM_FLDS-1:0] stop_q, stop_d;
  logic [7:0]          type_q, type_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  err_e                err_q, err_d;

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  logic [SIZE_W-1:0] size_nx;
  logic [NUM_W-1:0]  mode_nx, major_nx, minor_nx;
  logic              size_dig, mode_dig, major_dig, minor_dig;
  logic              last, zero_now, special, content;

  assign s0_fire    = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || s0_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_byte_q <= in_i.data_byte;
      s0_eof_q  <= in_i.end_of_feed;
    end
  end

  tsd_oct_acc #(.W(SIZE_W)) u_size (
    .acc_i(size_q), .char_i(s0_byte_q), .acc_o(size_nx), .digit_o(size_dig)
  );
  tsd_oct_acc #(.W(NUM_W)) u_mode (
    .acc_i(mode_q), .char_i(s0_byte_q), .acc_o(mode_nx), .digit_o(mode_dig)
  );
  tsd_oct_acc #(.W(NUM_W)) u_major (
    .acc_i(major_q), .char_i(s0_byte_q), .acc_o(major_nx), .digit_o(major_dig)
  );
  tsd_oct_acc #(.W(NUM_W)) u_minor (
    .acc_i(minor_q), .char_i(s0_byte_q), .acc_o(minor_nx), .digit_o(minor_dig)
  );

  assign last     = (off_q == LAST_OFF);
  assign zero_now = az_q && (s0_byte_q == 8'h00);
  assign special  = (type_q >= TYPE_LINK_LO) && (type_q <= TYPE_LINK_HI);
  assign content  = !special && (size_q != '0);

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    az_d    = az_q;
    size_d  = size_q;
    mode_d  = mode_q;
    major_d = major_q;
    minor_d = minor_q;
    stop_d  = stop_q;
    type_d  = type_q;
    rem_d   = rem_q;
    err_d   = err_q;
    res_d   = '0;
    res_d.byte_out = s0_eof_q ? 8'h00 : s0_byte_q;

    if (s0_eof_q) begin
      if (err_q == ERR_NONE && (phase_q != PH_END || off_q != '0)) begin
        err_d = ERR_EARLY_END;
      end
      res_d.byte_kind = KIND_FEED_END;
    end else if (err_q != ERR_NONE) begin
      res_d.byte_kind = KIND_DROPPED;
    end else begin
      case (phase_q)
        PH_CONTENT: begin
          if (rem_q != '0) begin
            res_d.byte_kind = KIND_DATA;
            rem_d = rem_q - SIZE_W'(1);
          end else begin
            res_d.byte_kind = KIND_PAD;
          end
          if (last && rem_d == '0) begin
            phase_d = PH_START;
          end
        end
        PH_END: begin
          res_d.byte_kind = KIND_END;
          if (last && !zero_now) begin
            err_d = ERR_TRAILING;
          end
        end
        default: begin
          res_d.byte_kind = KIND_HEADER;
          if (off_q == '0) begin
            size_d  = '0;
            mode_d  = '0;
            major_d = '0;
            minor_d = '0;
            stop_d  = '0;
            type_d  = '0;
          end
          // a field stops at its first non-octal character
          if (off_q inside {[SIZE_OFF:SIZE_OFF+SIZE_LEN-1]} && !stop_q[FLD_SIZE]) begin
            if (size_dig) size_d = size_nx;
            else          stop_d[FLD_SIZE] = 1'b1;
          end
          if (off_q inside {[MODE_OFF:MODE_OFF+MODE_LEN-1]} && !stop_q[FLD_MODE]) begin
            if (mode_dig) mode_d = mode_nx;
            else          stop_d[FLD_MODE] = 1'b1;
          end
          if (off_q inside {[MAJOR_OFF:MAJOR_OFF+DEV_LEN-1]} && !stop_q[FLD_MAJOR]) begin
            if (major_dig) major_d = major_nx;
            else           stop_d[FLD_MAJOR] = 1'b1;
          end
          if (off_q inside {[MINOR_OFF:MINOR_OFF+DEV_LEN-1]} && !stop_q[FLD_MINOR]) begin
            if (minor_dig) minor_d = minor_nx;
            else           stop_d[FLD_MINOR] = 1'b1;
          end
          if (off_q == OFF_W'(TYPE_OFF)) begin
            type_d = s0_byte_q;
          end
          // no field sits in the last byte, so the held values are final
          if (last) begin
            res_d.header_done = 1'b1;
            if (zero_now) begin
              res_d.archive_end = 1'b1;
              phase_d = PH_END;
            end else begin
              res_d.has_content = content;
              res_d.entry_type  = type_q;
              res_d.file_size   = size_q;
              res_d.file_mode   = mode_q;
              res_d.dev_major   = major_q;
              res_d.dev_minor   = minor_q;
              if (content) begin
                rem_d   = size_q;
                phase_d = PH_CONTENT;
              end else begin
                phase_d = PH_START;
              end
            end
          end
        end
      endcase
      az_d  = last ? 1'b1 : zero_now;
      off_d = last ? '0 : off_q + OFF_W'(1);
    end
    res_d.error_code = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      off_q   <= '0;
      az_q    <= 1'b1;
      size_q  <= '0;
      mode_q  <= '0;
      major_q <= '0;
      minor_q <= '0;
      stop_q  <= '0;
      type_q  <= '0;
      rem_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (s0_fire) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      az_q    <= az_d;
      size_q  <= size_d;
      mode_q  <= mode_d;
      major_q <= major_d;
      minor_q <= minor_d;
      stop_q  <= stop_d;
      type_q  <= type_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s0_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.byte_out    = res_q.byte_out;
  assign out_o.byte_kind   = res_q.byte_kind;
  assign out_o.header_done = res_q.header_done;
  assign out_o.archive_end = res_q.archive_end;
  assign out_o.has_content = res_q.has_content;
  assign out_o.entry_type  = res_q.entry_type;
  assign out_o.file_size   = res_q.file_size;
  assign out_o.file_mode   = res_q.file_mode;
  assign out_o.dev_major   = res_q.dev_major;
  assign out_o.dev_minor   = res_q.dev_minor;
  assign out_o.error_code  = res_q.error_code;

`ifndef SYNTH
  // an end marker only ever comes with the last byte of a header block
  a_end_on_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.archive_end |->
      out_o.header_done && out_o.byte_kind == KIND_HEADER)
    else $error("archive_end outside a finished header block");

  // first error is held until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ERR_NONE |=> err_q == $past(err_q))
    else $error("sticky error changed");

  // a held input beat is not overwritten while the result side stalls
  a_s0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !s0_fire |=> s0_valid_q && $stable(s0_byte_q) && $stable(s0_eof_q))
    else $error("input register lost a beat");
`endif

endmodule

>>> hdl/tsd_oct_acc.sv
// ----------------------------------------------------------------------------
// tsd_oct_acc
// Saturating octal shift-in of one character into a field accumulator.
// ----------------------------------------------------------------------------
module tsd_oct_acc #(
  parameter int unsigned W = 21
) (
  input  logic [W-1:0] acc_i,
  input  logic [7:0]   char_i,
  output logic [W-1:0] acc_o,
  output logic         digit_o
);

  logic sat;

  assign digit_o = char_i inside {[8'h30:8'h37]};
  // acc*8+d fits only while the top three bits are clear
  assign sat     = |acc_i[W-1:W-3];
  assign acc_o   = sat ? '1 : {acc_i[W-4:0], char_i[2:0]};

endmodule
